// ----- hdl/dcac_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcac_pkg
// Shared types, codes and helpers of the copy-address cache.
// ----------------------------------------------------------------------------
package dcac_pkg;

  localparam int NEAR_MAX_DEF = 8;
  localparam int SAME_MAX_DEF = 4;
  localparam int ADDR_BITS    = 32;
  localparam int BLOCK_BITS   = 8;
  localparam int CFG_W        = 4;

  typedef logic [1:0]  func_t;
  typedef logic [31:0] word_t;
  typedef logic [7:0]  mode_t;
  typedef logic [1:0]  status_t;
  typedef logic [0:0]  cfg_idx_t;
  typedef logic [CFG_W-1:0] cfg_data_t;

  localparam func_t FUNC_ENCODE = 2'd0;
  localparam func_t FUNC_DECODE = 2'd1;
  localparam func_t FUNC_CLEAR  = 2'd2;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_BAD_MODE = 2'd1;
  localparam status_t ST_BAD_HERE = 2'd2;

  localparam cfg_idx_t CFG_NEAR_COUNT = 1'd0;
  localparam cfg_idx_t CFG_SAME_COUNT = 1'd1;

  localparam mode_t MODE_SELF = 8'd0;
  localparam mode_t MODE_HERE = 8'd1;
  localparam mode_t MODE_NEAR = 8'd2;

  localparam word_t ADDR_MASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF :
                                word_t'((64'd1 << ADDR_BITS) - 64'd1);

  // bytes of a 7-bit-per-byte varint
  function automatic logic [2:0] vlen(input word_t v);
    logic [2:0] n;
    n = 3'd1;
    if (v >= 32'h0000_0080) n = 3'd2;
    if (v >= 32'h0000_4000) n = 3'd3;
    if (v >= 32'h0020_0000) n = 3'd4;
    if (v >= 32'h1000_0000) n = 3'd5;
    return n;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/dcac_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcac_if
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
interface dcac_in_if;
  logic             valid;
  logic             ready;
  dcac_pkg::func_t  func;
  dcac_pkg::word_t  value;
  dcac_pkg::word_t  here;
  dcac_pkg::mode_t  mode;
  modport source (output valid, func, value, here, mode, input ready);
  modport sink   (input valid, func, value, here, mode, output ready);
endinterface

interface dcac_out_if;
  logic               valid;
  logic               ready;
  dcac_pkg::word_t    out_value;
  dcac_pkg::mode_t    out_mode;
  dcac_pkg::status_t  status;
  modport source (output valid, out_value, out_mode, status, input ready);
  modport sink   (input valid, out_value, out_mode, status, output ready);
endinterface
`default_nettype wire

// ----- hdl/delta_copy_address_cache_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// delta_copy_address_cache_unit
// Near/same copy-address cache: encodes and decodes copy addresses.
// ----------------------------------------------------------------------------
// in_ch takes one item at a time (func: encode, decode, clear); out_ch returns
// exactly one result item per request. cfg_we/cfg_index/cfg_data set the near
// slot count and the same block count; write them only while the unit is idle.
// Encode: accept, a bit-serial remainder for the same-cache block (skipped
// when no blocks are in use), a scan of the near slots in use (ended early by
// a one-byte delta), the same-cache read and compare (skipped when no blocks
// are in use or a one-byte delta is found), update and output. Decode:
// accept, a same-table read for a same mode, the remainder when blocks
// are in use, update and output; decode errors go from accept to output.
// Clear zeroes same_count*256 same-table entries, one per cycle. After
// reset all SAME_MAX*256 entries are swept to zero, with in_ch.ready low.
// A finished result waits in the output register; the next item is accepted
// meanwhile, but it cannot finish until out_ch.ready takes the waiting one.
// ----------------------------------------------------------------------------
module delta_copy_address_cache_unit #(
  parameter int NEAR_MAX = dcac_pkg::NEAR_MAX_DEF,
  parameter int SAME_MAX = dcac_pkg::SAME_MAX_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  dcac_in_if.sink             in_ch,
  dcac_out_if.source          out_ch,
  input  wire                 cfg_we,
  input  dcac_pkg::cfg_idx_t  cfg_index,
  input  dcac_pkg::cfg_data_t cfg_data
);
  import dcac_pkg::*;

  localparam int NI    = $clog2(NEAR_MAX + 1);
  localparam int NIDX  = (NEAR_MAX > 1) ? $clog2(NEAR_MAX) : 1;
  localparam int SB    = (SAME_MAX > 1) ? $clog2(SAME_MAX) : 1;
  localparam int RW    = $clog2(SAME_MAX + 1) + 1;
  localparam int MW    = BLOCK_BITS + SB;
  localparam int DEPTH = SAME_MAX * 256;
  localparam int QW    = 32 - BLOCK_BITS;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DRD, S_DDAT, S_MOD, S_NEAR, S_SRD, S_SCMP, S_UPD, S_DONE
  } state_t;

  state_t          state;
  logic [3:0]      near_count;
  logic [2:0]      same_count;
  word_t           near_slots [NEAR_MAX];
  logic [NIDX-1:0] near_next;
  word_t           mem [DEPTH];
  word_t           rdata;

  func_t           f;
  word_t           a;
  word_t           bestd;
  mode_t           bestm;
  logic [2:0]      bestsz;
  logic [QW-1:0]   q;
  logic [RW-1:0]   r;
  logic [4:0]      k;
  logic [NI-1:0]   i;
  logic [MW-1:0]   raddr;
  logic [MW-1:0]   cnt;
  logic [SB-1:0]   clr_last;
  logic            clr_boot;
  word_t           res;
  mode_t           rmode;
  status_t         rstatus;
  logic            ov;

  logic [NI-1:0]   nc;
  logic [RW-1:0]   sc;
  logic [SB-1:0]   blk;
  logic [MW-1:0]   rd_addr;
  logic            mem_we;
  logic [MW-1:0]   wr_addr;
  word_t           wr_data;
  logic [RW-1:0]   r2;
  logic [8:0]      md;
  logic [8:0]      ms;
  word_t           slot_i;
  word_t           dnear;
  logic [2:0]      dlen;
  logic [NI-1:0]   nidx;
  logic [NI-1:0]   nn1;
  word_t           hd;
  word_t           dsum;
  word_t           dec_addr;
  logic            dec_same;
  status_t         dec_status;
  word_t           a_in;

  assign nc = NI'((32'(near_count) > 32'(NEAR_MAX)) ? 32'(NEAR_MAX) : 32'(near_count));
  assign sc = RW'((32'(same_count) > 32'(SAME_MAX)) ? 32'(SAME_MAX) : 32'(same_count));
  assign blk = r[SB-1:0];

  assign md = 9'(in_ch.mode) - 9'd2;
  assign ms = 9'(in_ch.mode) - 9'd2 - 9'(nc);
  assign hd = in_ch.here - in_ch.value;
  assign dsum = (near_slots[md[NIDX-1:0]] + in_ch.value) & ADDR_MASK;

  // decoded address and status of an incoming decode item
  assign dec_same = (in_ch.mode != MODE_SELF) && (in_ch.mode != MODE_HERE) &&
                    (md >= 9'(nc));
  assign dec_status = (in_ch.mode == MODE_HERE && in_ch.value > in_ch.here) ? ST_BAD_HERE :
                      (dec_same && ms >= 9'(sc)) ? ST_BAD_MODE : ST_OK;

  always_comb begin
    dec_addr = in_ch.value;
    if (in_ch.mode == MODE_HERE) dec_addr = hd;
    else if (in_ch.mode != MODE_SELF && md < 9'(nc)) dec_addr = dsum;
  end

  assign a_in = (in_ch.func == FUNC_DECODE) ? dec_addr : in_ch.value;

  assign slot_i = near_slots[i[NIDX-1:0]];
  assign dnear  = a - slot_i;
  assign dlen   = vlen(dnear);

  always_comb begin
    r2 = {r[RW-2:0], q[QW-1]};
    if (r2 >= sc) r2 = r2 - sc;
  end

  assign nidx = (NI'(near_next) < nc) ? NI'(near_next) : '0;
  assign nn1  = nidx + NI'(1);

  assign rd_addr = (state == S_SRD) ? {blk, a[BLOCK_BITS-1:0]} : raddr;
  assign mem_we  = (state == S_CLR) || (state == S_UPD && sc != '0);
  assign wr_addr = (state == S_CLR) ? cnt : {blk, a[BLOCK_BITS-1:0]};
  assign wr_data = (state == S_CLR) ? '0 : a;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rdata <= mem[rd_addr];
  end

  assign in_ch.ready      = (state == S_IDLE);
  assign out_ch.valid     = ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      near_count <= 4'd4;
      same_count <= 3'd3;
      near_next  <= '0;
      cnt        <= '0;
      clr_last   <= SB'(SAME_MAX - 1);
      clr_boot   <= 1'b1;
      ov         <= 1'b0;
      for (int n = 0; n < NEAR_MAX; n++) near_slots[n] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NEAR_COUNT: near_count <= cfg_data[3:0];
          CFG_SAME_COUNT: same_count <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (state == S_DONE && (!ov || out_ch.ready)) ov <= 1'b1;
      else if (out_ch.ready) ov <= 1'b0;

      case (state)
        S_CLR: begin
          cnt <= cnt + MW'(1);
          if (cnt == {clr_last, {BLOCK_BITS{1'b1}}}) begin
            state <= clr_boot ? S_IDLE : S_DONE;
            clr_boot <= 1'b0;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            f       <= in_ch.func;
            a       <= a_in;
            res     <= '0;
            rmode   <= MODE_SELF;
            rstatus <= (in_ch.func == FUNC_DECODE) ? dec_status : ST_OK;
            q       <= a_in[31:BLOCK_BITS];
            r       <= '0;
            k       <= '0;
            i       <= '0;
            case (in_ch.func)
              FUNC_ENCODE: begin
                if (vlen(in_ch.value) > 3'd1 && in_ch.value <= in_ch.here &&
                    vlen(hd) < vlen(in_ch.value)) begin
                  bestd  <= hd;
                  bestm  <= MODE_HERE;
                  bestsz <= vlen(hd);
                end else begin
                  bestd  <= in_ch.value;
                  bestm  <= MODE_SELF;
                  bestsz <= vlen(in_ch.value);
                end
                state <= (sc != '0) ? S_MOD : S_NEAR;
              end
              FUNC_DECODE: begin
                if (dec_status != ST_OK) begin
                  state <= S_DONE;
                end else if (dec_same) begin
                  raddr <= {ms[SB-1:0], in_ch.value[BLOCK_BITS-1:0]};
                  state <= S_DRD;
                end else begin
                  state <= (sc != '0) ? S_MOD : S_UPD;
                end
              end
              FUNC_CLEAR: begin
                for (int n = 0; n < NEAR_MAX; n++)
                  if (NI'(n) < nc) near_slots[n] <= '0;
                near_next <= '0;
                cnt       <= '0;
                clr_last  <= SB'(sc - RW'(1));
                state     <= (sc != '0) ? S_CLR : S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_DRD: state <= S_DDAT;
        S_DDAT: begin
          a     <= rdata;
          q     <= rdata[31:BLOCK_BITS];
          state <= (sc != '0) ? S_MOD : S_UPD;
        end
        S_MOD: begin
          r <= r2;
          q <= {q[QW-2:0], 1'b0};
          k <= k + 5'd1;
          if (k == 5'(QW - 1)) state <= (f == FUNC_ENCODE) ? S_NEAR : S_UPD;
        end
        S_NEAR: begin
          if (i < nc && bestsz > 3'd1) begin
            if (a >= slot_i && dlen < bestsz) begin
              bestd  <= dnear;
              bestm  <= mode_t'(32'(MODE_NEAR) + 32'(i));
              bestsz <= dlen;
            end
            i <= i + NI'(1);
          end else begin
            state <= (sc != '0 && bestsz > 3'd1) ? S_SRD : S_UPD;
          end
        end
        S_SRD: state <= S_SCMP;
        S_SCMP: begin
          if (rdata == a) begin
            bestd <= 32'(a[BLOCK_BITS-1:0]);
            bestm <= mode_t'(32'(MODE_NEAR) + 32'(nc) + 32'(blk));
          end
          state <= S_UPD;
        end
        S_UPD: begin
          if (nc != '0) begin
            near_slots[nidx[NIDX-1:0]] <= a;
            near_next <= (nn1 >= nc) ? '0 : nn1[NIDX-1:0];
          end
          if (f == FUNC_ENCODE) begin
            res   <= bestd;
            rmode <= bestm;
          end else begin
            res <= a;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!ov || out_ch.ready) begin
            out_ch.out_value <= res;
            out_ch.out_mode  <= rmode;
            out_ch.status    <= rstatus;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/dcac_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcac_checker
// Port-level checks of the copy-address cache, bound to the top level.
// ----------------------------------------------------------------------------
module dcac_checker (
  input wire                    clk,
  input wire                    rst,
  input wire                    in_valid,
  input wire                    in_ready,
  input wire                    out_valid,
  input wire                    out_ready,
  input wire dcac_pkg::word_t   out_value,
  input wire dcac_pkg::mode_t   out_mode,
  input wire dcac_pkg::status_t status
);
  import dcac_pkg::*;

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_BAD_MODE || status == ST_BAD_HERE))
    else $error("status code out of range");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (out_value == '0 && out_mode == MODE_SELF))
    else $error("error result carries data");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value) &&
                                   $stable(out_mode) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind delta_copy_address_cache_unit dcac_checker u_dcac_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.out_value),
  .out_mode  (out_ch.out_mode),
  .status    (out_ch.status)
);
`default_nettype wire
